/* design/obst_pkg.sv */
// Shared types and fixed widths for the optimal BST cost table block.
// No dependencies; imported by the top level.
package obst_pkg;

    localparam int IDX_W   = 4;
    localparam int FIELD_W = 16;
    localparam int COST_W  = 26;
    localparam int WSUM_W  = 21;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [COST_W-1:0] cost_t;
    typedef logic [WSUM_W-1:0] wsum_t;

    localparam cost_t COST_MAX = '1;
    localparam wsum_t WSUM_MAX = '1;

endpackage

/* design/obst_ram.sv */
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module obst_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 90
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

/* design/optimal_bst_cost_table.sv */
// Optimal BST cost table: weight loader, table-fill sequencer, weight-sum and cost adders, compare.
// Depends on obst_pkg and obst_ram (cost table storage).
//
// Channel   Direction  Handshake            Payload
// load      in         start & !busy        key_weight, gap_weight, last
// result    out        strobe (one cycle)   range_first, range_end, best_root,
//                                           expected_cost, final_result
//
// Loads are taken on start while idle; busy is high for the whole fill, which starts
// after a load with last set and walks subranges by length; each seeds the weight sum
// (S_WINIT), accumulates key and gap weights (S_WACC), does cost RAM read, add and
// compare per root (S_RD, S_SUM, S_CMP), then writes/emits (S_WR); zero keys use S_ZERO.
// Reset clears the load count and sequencer; table contents are left as they are.
// The result side cannot stall; each result appears for exactly one cycle.
module optimal_bst_cost_table
    import obst_pkg::*;
#(
    parameter int MAX_KEYS    = 8,
    parameter int WEIGHT_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [FIELD_W-1:0] key_weight,
    input  logic [FIELD_W-1:0] gap_weight,
    input  logic               last,
    output logic               strobe,
    output logic [IDX_W-1:0]   range_first,
    output logic [IDX_W-1:0]   range_end,
    output logic [IDX_W-1:0]   best_root,
    output logic [COST_W-1:0]  expected_cost,
    output logic               final_result
);

    localparam int WS        = (WEIGHT_BITS < FIELD_W) ? WEIGHT_BITS : FIELD_W;
    localparam int NSLOT     = MAX_KEYS + 1;
    localparam int WIDX      = $clog2(NSLOT);
    localparam int STRIDE    = MAX_KEYS + 1;
    localparam int RAM_DEPTH = (MAX_KEYS + 2) * (MAX_KEYS + 1);
    localparam int AW        = $clog2(RAM_DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ZERO  = 3'd1;
    localparam logic [2:0] S_WINIT = 3'd2;
    localparam logic [2:0] S_WACC  = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_SUM   = 3'd5;
    localparam logic [2:0] S_CMP   = 3'd6;
    localparam logic [2:0] S_WR    = 3'd7;

    typedef logic [WS-1:0] weight_t;

    function automatic logic [AW-1:0] cell_addr(idx_t row, idx_t col);
        return AW'(int'(row) * STRIDE + int'(col));
    endfunction

    logic [2:0] state_reg, state_next;
    idx_t       load_cnt_reg, load_cnt_next;
    idx_t       n_reg, n_next;
    idx_t       len_reg, len_next;
    idx_t       i_reg, i_next;
    idx_t       j_reg, j_next;
    idx_t       k_reg, k_next;
    wsum_t      wsum_reg, wsum_next;
    cost_t      tsum_reg, tsum_next;
    cost_t      best_reg, best_next;
    idx_t       root_reg, root_next;

    logic       strobe_reg, strobe_next;
    idx_t       rf_reg, rf_next;
    idx_t       re_reg, re_next;
    idx_t       ro_reg, ro_next;
    cost_t      co_reg, co_next;
    logic       fin_reg, fin_next;

    weight_t    key_w_reg [NSLOT];
    weight_t    gap_w_reg [NSLOT];
    logic       load_we;
    idx_t       cnt_after;
    idx_t       gidx;
    weight_t    key_rd;
    weight_t    gap_rd;

    logic [WSUM_W+1:0] wacc_sum;
    logic [COST_W+1:0] tsum_full;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    cost_t             ram_wdata;
    cost_t             rd_a;
    cost_t             rd_b;

    obst_ram #(
        .WIDTH (COST_W),
        .DEPTH (RAM_DEPTH)
    ) u_cost_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (cell_addr(i_reg, k_reg - idx_t'(1))),
        .rdata_a (rd_a),
        .raddr_b (cell_addr(k_reg + idx_t'(1), j_reg)),
        .rdata_b (rd_b)
    );

    assign gidx   = (state_reg == S_WINIT) ? (i_reg - idx_t'(1)) : k_reg;
    assign gap_rd = gap_w_reg[gidx[WIDX-1:0]];
    assign key_rd = key_w_reg[k_reg[WIDX-1:0]];

    assign wacc_sum  = {2'b00, wsum_reg} + (WSUM_W+2)'(key_rd) + (WSUM_W+2)'(gap_rd);
    assign tsum_full = {2'b00, rd_a} + {2'b00, rd_b} + (COST_W+2)'(wsum_reg);

    always_comb
    begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        n_next        = n_reg;
        len_next      = len_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        wsum_next     = wsum_reg;
        tsum_next     = tsum_reg;
        best_next     = best_reg;
        root_next     = root_reg;
        strobe_next   = 1'b0;
        rf_next       = rf_reg;
        re_next       = re_reg;
        ro_next       = ro_reg;
        co_next       = co_reg;
        fin_next      = fin_reg;
        load_we       = 1'b0;
        cnt_after     = load_cnt_reg;
        ram_we        = 1'b0;
        ram_waddr     = cell_addr(load_cnt_reg + idx_t'(1), load_cnt_reg);
        ram_wdata     = COST_W'(gap_weight[WS-1:0]);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (load_cnt_reg < idx_t'(NSLOT))
                    begin
                        load_we   = 1'b1;
                        ram_we    = 1'b1;
                        cnt_after = load_cnt_reg + idx_t'(1);
                    end
                    if (last)
                    begin
                        load_cnt_next = '0;
                        n_next        = cnt_after - idx_t'(1);
                        if (cnt_after == idx_t'(1))
                        begin
                            state_next = S_ZERO;
                        end
                        else
                        begin
                            len_next   = idx_t'(1);
                            i_next     = idx_t'(1);
                            j_next     = idx_t'(1);
                            state_next = S_WINIT;
                        end
                    end
                    else
                    begin
                        load_cnt_next = cnt_after;
                    end
                end
            end
            S_ZERO:
            begin
                strobe_next = 1'b1;
                rf_next     = idx_t'(1);
                re_next     = '0;
                ro_next     = '0;
                co_next     = COST_W'(gap_w_reg[0]);
                fin_next    = 1'b1;
                state_next  = S_IDLE;
            end
            S_WINIT:
            begin
                wsum_next  = WSUM_W'(gap_rd);
                k_next     = i_reg;
                state_next = S_WACC;
            end
            S_WACC:
            begin
                wsum_next = (wacc_sum > (WSUM_W+2)'(WSUM_MAX)) ? WSUM_MAX
                                                                : wacc_sum[WSUM_W-1:0];
                if (k_reg == j_reg)
                begin
                    k_next     = i_reg;
                    state_next = S_RD;
                end
                else
                begin
                    k_next = k_reg + idx_t'(1);
                end
            end
            S_RD:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                tsum_next  = (tsum_full > (COST_W+2)'(COST_MAX)) ? COST_MAX
                                                                  : tsum_full[COST_W-1:0];
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if ((k_reg == i_reg) || (tsum_reg < best_reg))
                begin
                    best_next = tsum_reg;
                    root_next = k_reg;
                end
                if (k_reg == j_reg)
                begin
                    state_next = S_WR;
                end
                else
                begin
                    k_next     = k_reg + idx_t'(1);
                    state_next = S_RD;
                end
            end
            S_WR:
            begin
                ram_we      = 1'b1;
                ram_waddr   = cell_addr(i_reg, j_reg);
                ram_wdata   = best_reg;
                strobe_next = 1'b1;
                rf_next     = i_reg;
                re_next     = j_reg;
                ro_next     = root_reg;
                co_next     = best_reg;
                fin_next    = (len_reg == n_reg);
                if (j_reg == n_reg)
                begin
                    if (len_reg == n_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        len_next   = len_reg + idx_t'(1);
                        i_next     = idx_t'(1);
                        j_next     = len_reg + idx_t'(1);
                        state_next = S_WINIT;
                    end
                end
                else
                begin
                    i_next     = i_reg + idx_t'(1);
                    j_next     = j_reg + idx_t'(1);
                    state_next = S_WINIT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            load_cnt_reg <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        len_reg  <= len_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        k_reg    <= k_next;
        wsum_reg <= wsum_next;
        tsum_reg <= tsum_next;
        best_reg <= best_next;
        root_reg <= root_next;
        rf_reg   <= rf_next;
        re_reg   <= re_next;
        ro_reg   <= ro_next;
        co_reg   <= co_next;
        fin_reg  <= fin_next;
        if (load_we)
        begin
            key_w_reg[load_cnt_reg[WIDX-1:0]] <= key_weight[WS-1:0];
            gap_w_reg[load_cnt_reg[WIDX-1:0]] <= gap_weight[WS-1:0];
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign strobe        = strobe_reg;
    assign range_first   = rf_reg;
    assign range_end     = re_reg;
    assign best_root     = ro_reg;
    assign expected_cost = co_reg;
    assign final_result  = fin_reg;

endmodule

/* design/obst_checker.sv */
// Port-level assertions for optimal_bst_cost_table, attached with a bind.
// No package dependency.
module obst_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        last,
    input logic        strobe,
    input logic [3:0]  range_first,
    input logic [3:0]  range_end,
    input logic [3:0]  best_root,
    input logic        final_result
);

    // results only come out of a running fill
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("result without a running fill");

    // the fill ends exactly with the final result
    a_end_final: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (strobe && final_result))
        else $error("fill ended without final result");

    // a load without last keeps the block idle; with last it starts the fill
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy == $past(last)))
        else $error("busy does not follow last on load");

    // chosen root lies inside a nonempty range
    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && range_end != 4'd0) |->
            (best_root >= range_first && best_root <= range_end))
        else $error("root outside its range");

endmodule

bind optimal_bst_cost_table obst_checker u_obst_checker (.*);
